FILE: rtl/band_depth_counter_defines.svh
// assertion macros for the band depth counter
`ifndef BAND_DEPTH_COUNTER_DEFINES_SVH
`define BAND_DEPTH_COUNTER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define BDC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define BDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/bdc_pkg.sv
// shared types and constants for the band depth counter
`default_nettype none
package bdc_pkg;
    localparam int unsigned DefMaxFunctions = 1024;
    localparam int unsigned DefMaxPoints    = 6;
    localparam int unsigned SampleW         = 32;
    localparam int unsigned CountW          = 40;
    localparam int unsigned NumFuncCfgW     = 11;
    localparam int unsigned NumPtsCfgW      = 3;
    localparam int unsigned FuncIdxW        = 10;
    localparam int unsigned PtIdxW          = 3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_NUM_FUNCTIONS = 1'b0;
    localparam logic CFG_NUM_POINTS    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_f;      // capture the queried function samples
        logic clear;       // clear counters
        logic scan;        // compare one function
        logic fin_start;   // start final accumulation
        logic fin_step;    // one accumulation step
    } bdc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic fin_done;
    } bdc_sts_t;
endpackage
`default_nettype wire

FILE: rtl/bdc_datapath.sv
// sample store, compare lanes, pattern counters and pair sum
`default_nettype none
module bdc_datapath
    import bdc_pkg::*;
#(
    parameter int unsigned MAX_FUNCTIONS = DefMaxFunctions,
    parameter int unsigned MAX_POINTS    = DefMaxPoints
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire bdc_cmd_t                cmd,
    output bdc_sts_t                     sts,
    input  wire logic                    wr_en,
    input  wire logic [FuncIdxW-1:0]     in_func,
    input  wire logic [PtIdxW-1:0]       in_pt,
    input  wire logic [SampleW-1:0]      in_val,
    input  wire logic [NumFuncCfgW-1:0]  cfg_n,
    input  wire logic [NumPtsCfgW-1:0]   cfg_m,
    output logic [CountW-1:0]            result
);
    localparam int unsigned FW = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
    localparam int unsigned CW = $clog2(MAX_FUNCTIONS + 1);
    localparam int unsigned NP = 1 << MAX_POINTS;
    localparam int unsigned VW = (MAX_POINTS > 1) ? MAX_POINTS - 1 : 1;

    logic [FW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      n_reg;
    logic [3:0]         m_reg;
    logic               rd_valid_reg;
    logic [CW-1:0]      cnt_reg [NP];
    logic [CW-1:0]      eq_reg;
    logic [VW-1:0]      v_reg;
    logic               fin_busy_reg;
    logic [CountW-1:0]  acc_reg;
    logic [CountW-1:0]  prod_reg;
    logic               prod_valid_reg;
    logic               fin_last_reg;
    logic               scan_cnt;
    logic [MAX_POINTS-1:0] gt, lt;
    logic [CW-1:0]      n_sat;
    logic [3:0]         m_sat;

    always_comb begin
        n_sat = (32'(cfg_n) > MAX_FUNCTIONS) ? CW'(MAX_FUNCTIONS) : CW'(cfg_n);
        m_sat = (32'(cfg_m) > MAX_POINTS) ? 4'(MAX_POINTS) : 4'(cfg_m);
    end

    // one memory per point, all read together
    for (genvar p = 0; p < MAX_POINTS; p++) begin : g_pt
        logic [SampleW-1:0] mem [MAX_FUNCTIONS];
        logic [SampleW-1:0] rd_reg;
        logic [SampleW-1:0] f_reg;
        always_ff @(posedge aclk) begin
            if (wr_en && 32'(in_func) < MAX_FUNCTIONS && 32'(in_pt) == p)
                mem[FW'(in_func)] <= in_val;
            rd_reg <= mem[addr_next];
            if (cmd.load_f)
                f_reg <= mem[FW'(in_func)];
        end
        always_comb begin
            gt[p] = 1'b0;
            lt[p] = 1'b0;
            if (p < m_reg) begin
                gt[p] = $signed(rd_reg) > $signed(f_reg);
                lt[p] = $signed(rd_reg) < $signed(f_reg);
            end
        end
    end

    // scan address sequencing, the read data is registered
    always_comb begin
        addr_next = addr_reg;
        if (cmd.load_f)
            addr_next = '0;
        else if (cmd.scan && rd_valid_reg)
            addr_next = addr_reg + FW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            n_reg <= '0;
            m_reg <= '0;
        end else begin
            addr_reg <= addr_next;
            rd_valid_reg <= cmd.scan && !rd_valid_reg ? 1'b1 :
                            (cmd.load_f ? 1'b0 : rd_valid_reg);
            if (cmd.load_f) begin
                n_reg <= n_sat;
                m_reg <= m_sat;
            end
        end
    end
    assign sts.scan_last = cmd.scan && rd_valid_reg && (32'(addr_reg) + 1 >= 32'(n_reg));

    // no function takes part when n is zero
    assign scan_cnt = cmd.scan && rd_valid_reg && (n_reg != '0);

    for (genvar v = 0; v < NP; v++) begin : g_cnt
        logic hit;
        always_comb
            hit = ((gt & ~MAX_POINTS'(v)) == '0) && ((lt & MAX_POINTS'(v)) == '0);
        always_ff @(posedge aclk) begin
            if (cmd.clear)
                cnt_reg[v] <= '0;
            else if (scan_cnt && hit)
                cnt_reg[v] <= cnt_reg[v] + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear)
            eq_reg <= '0;
        else if (scan_cnt && gt == '0 && lt == '0)
            eq_reg <= eq_reg + CW'(1);
    end

    // final sum: one pattern product a step, base terms first
    logic [CW-1:0] lo_cnt, hi_cnt;
    logic [4:0]    mcl;
    logic [VW:0]   half;
    logic          step_last;
    logic [MAX_POINTS-1:0] vfull, vcomp;
    always_comb begin
        vfull  = MAX_POINTS'(v_reg);
        vcomp  = MAX_POINTS'((1 << m_reg) - 1) ^ vfull;
        lo_cnt = cnt_reg[vfull] - eq_reg;
        hi_cnt = cnt_reg[vcomp] - eq_reg;
        mcl    = 5'(m_reg);
        half   = (m_reg == 0) ? '0 : (VW+1)'(1 << (mcl - 5'd1));
        step_last = ((VW+1)'(v_reg) + (VW+1)'(1)) >= half;
    end

    logic [CountW-1:0] base;
    always_comb
        base = CountW'(n_reg - eq_reg) * CountW'(eq_reg) +
               ((CountW'(eq_reg) * CountW'(eq_reg - CW'(eq_reg != 0))) >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_busy_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            fin_last_reg <= 1'b0;
            v_reg <= '0;
        end else begin
            prod_valid_reg <= fin_busy_reg && cmd.fin_step && !cmd.fin_start;
            if (cmd.fin_start) begin
                v_reg <= '0;
                fin_busy_reg <= (half != 0);
                fin_last_reg <= (half == 0);
            end else if (fin_busy_reg && cmd.fin_step) begin
                v_reg <= v_reg + VW'(1);
                fin_busy_reg <= !step_last;
                fin_last_reg <= step_last;
            end else begin
                fin_last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_start)
            acc_reg <= base;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + prod_reg;
        if (fin_busy_reg && cmd.fin_step && !cmd.fin_start)
            prod_reg <= CountW'(lo_cnt) * CountW'(hi_cnt);
    end

    assign sts.fin_done = fin_last_reg && !fin_busy_reg;
    assign result = acc_reg + (prod_valid_reg ? prod_reg : '0);
endmodule
`default_nettype wire

FILE: rtl/bdc_ctrl.sv
// controller state machine for writes, scans and the final sum
`default_nettype none
module bdc_ctrl
    import bdc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic         in_req,
    input  wire logic         in_out_of_range,
    output logic              in_ready,
    output logic              wr_en,
    output bdc_cmd_t          cmd,
    input  wire bdc_sts_t     sts,
    output logic              res_valid,
    output logic              res_zero,
    input  wire logic         res_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FIN0 = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       zero_reg, zero_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign wr_en     = in_valid && in_ready && in_req == REQ_WRITE;
    assign res_valid = (state_reg == ST_OUT);
    assign res_zero  = zero_reg;

    always_comb begin
        state_next = state_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_req == REQ_QUERY) begin
                    zero_next = in_out_of_range;
                    cmd.load_f = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = in_out_of_range ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) state_next = ST_FIN0;
            end
            ST_FIN0: begin
                cmd.fin_start = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin_step = 1'b1;
                if (sts.fin_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (res_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            zero_reg  <= zero_next;
        end
    end

`include "band_depth_counter_defines.svh"
    `BDC_ASSERT_IMP(a_wr_idle, aclk, aresetn, wr_en, state_reg == ST_IDLE)
    `BDC_ASSERT_NEXT(a_scan_end, aclk, aresetn, state_reg == ST_SCAN && sts.scan_last, state_reg == ST_FIN0)
    `BDC_ASSERT_NEXT(a_out_hold, aclk, aresetn, res_valid && !res_ready, res_valid)
endmodule
`default_nettype wire

FILE: rtl/band_depth_counter.sv
// top level of the band depth pair counter
// channel | dir | fields (lsb first)
// s_axis  | in  | req_type, function_index, point_index, sample_value
// m_axis  | out | depth_count
// cfg     | in  | 0 num_functions, 1 num_points
// a write is taken in idle; a query scans the functions, then sums the pattern products and offers
// the result (a function index out of range goes straight to a zero result)
// the scan reads each of the first n functions once from one memory port per point
// a stalled result holds the block; no new transaction until it leaves
// reset clears control and loads the default configuration, the sample store is undefined until written
`default_nettype none
module band_depth_counter
    import bdc_pkg::*;
#(
    parameter int unsigned MAX_FUNCTIONS = DefMaxFunctions,
    parameter int unsigned MAX_POINTS    = DefMaxPoints
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type, function_index, point_index, sample_value, zero fill
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // depth_count
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data
);
    logic [NumFuncCfgW-1:0] n_reg;
    logic [NumPtsCfgW-1:0]  m_reg;
    bdc_cmd_t cmd;
    bdc_sts_t sts;
    logic wr_en, res_zero;
    logic [CountW-1:0] result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= 11'd1024;
            m_reg <= 3'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_FUNCTIONS: n_reg <= cfg_data;
                CFG_NUM_POINTS:    m_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    bdc_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid),
        .in_req(s_tdata[0]),
        .in_out_of_range(32'(s_tdata[10:1]) >= MAX_FUNCTIONS),
        .in_ready(s_tready),
        .wr_en, .cmd, .sts,
        .res_valid(m_tvalid),
        .res_zero,
        .res_ready(m_tready)
    );

    bdc_datapath #(.MAX_FUNCTIONS(MAX_FUNCTIONS), .MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .wr_en,
        .in_func(s_tdata[10:1]),
        .in_pt(s_tdata[13:11]),
        .in_val(s_tdata[45:14]),
        .cfg_n(n_reg),
        .cfg_m(m_reg),
        .result
    );

    assign m_tdata = res_zero ? '0 : result;
endmodule
`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the band depth pair counter
`timescale 1ns / 100ps
`default_nettype none
module tb
    import bdc_pkg::*;
();

    typedef enum logic { ROW_CFG, ROW_XFER } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        idx;
        logic [10:0] cfg_val;
        logic        req;
        logic [9:0]  fn;
        logic [2:0]  pt;
        logic [31:0] val;
        bit          typed;
        logic [39:0] count;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_NUM_FUNCTIONS;
    logic [10:0] cfg_data = '0;

    logic signed [31:0] samples [DefMaxFunctions][DefMaxPoints];
    bit                 written [DefMaxFunctions][DefMaxPoints];
    logic [10:0]        cur_funcs = 11'd1024;
    logic [2:0]         cur_points = 3'd2;
    logic [39:0]        pending_counts [$];
    int                 fail_cnt = 0;
    int                 burst_left = 0;
    int                 ready_left = 0;
    int                 ready_mode = 0;

    band_depth_counter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    initial begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int eff_funcs();
        return (cur_funcs > DefMaxFunctions) ? DefMaxFunctions : int'(cur_funcs);
    endfunction

    function automatic int eff_points();
        return (cur_points > DefMaxPoints) ? DefMaxPoints : int'(cur_points);
    endfunction

    function automatic logic [39:0] band_count(input int f);
        int     n;
        int     m;
        int     np;
        int     gt;
        int     lt;
        longint eq;
        longint total;
        longint hits [64];
        n = eff_funcs();
        m = eff_points();
        np = 1 << m;
        eq = 0;
        foreach (hits[i]) hits[i] = 0;
        for (int g = 0; g < n; g++) begin
            gt = 0;
            lt = 0;
            for (int c = 0; c < m; c++) begin
                if (samples[g][c] > samples[f][c]) gt |= 1 << c;
                if (samples[g][c] < samples[f][c]) lt |= 1 << c;
            end
            if (gt == 0 && lt == 0) eq++;
            for (int v = 0; v < np; v++)
                if ((gt & ~v) == 0 && (lt & v) == 0) hits[v]++;
        end
        total = (longint'(n) - eq) * eq;
        if (eq > 0) total += eq * (eq - 1) / 2;
        for (int v = 0; v < np / 2; v++)
            total += (hits[v] - eq) * (hits[np - 1 - v] - eq);
        return total[39:0];
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(50, 300);
        end
        ready_left--;
        case (ready_mode)
            0: m_tready = 1'b1;
            1: m_tready = $urandom_range(0, 1);
            default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                $error("depth_count: unexpected transaction, actual %0d", m_tdata);
                fail_cnt++;
            end else begin
                if (m_tdata !== pending_counts[0]) begin
                    $error("depth_count: expected %0d, actual %0d",
                           pending_counts[0], m_tdata);
                    fail_cnt++;
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    task automatic send_item(input logic req, input logic [9:0] fn, input logic [2:0] pt,
                             input logic [31:0] val, input bit typed,
                             input logic [39:0] count);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata = {2'b00, val, pt, fn, req};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req == REQ_WRITE) begin
            if (pt < DefMaxPoints) begin
                samples[fn][pt] = val;
                written[fn][pt] = 1'b1;
            end
        end else begin
            pending_counts.push_back(typed ? count : band_count(fn));
        end
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [10:0] value);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_NUM_FUNCTIONS) cur_funcs = value;
        else cur_points = value[2:0];
    endtask

    // fill every entry the scan will read, then query
    task automatic query_item(input logic [9:0] fn);
        for (int g = 0; g < DefMaxFunctions; g++)
            for (int c = 0; c < eff_points(); c++)
                if ((g < eff_funcs() || g == fn) && !written[g][c])
                    send_item(REQ_WRITE, 10'(g), 3'(c), pick_sample(), 1'b0, '0);
        send_item(REQ_QUERY, fn, 3'($urandom), $urandom, 1'b0, '0);
    endtask

    stim_row_t rows [] = '{
        '{ROW_XFER, 0, 0, REQ_WRITE, 0, 0, 32'h8000_0000, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 0, 1, 32'h7fff_ffff, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 1, 0, 32'h7fff_ffff, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 1, 1, 32'h8000_0000, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 1023, 0, 32'h0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 1023, 1, 32'h0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 5, 7, 32'h1234_5678, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 6, 6, 32'hffff_ffff, 0, 0},
        '{ROW_CFG, CFG_NUM_FUNCTIONS, 11'd2, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 0, 0, 32'h0, 1, 40'd1},
        '{ROW_XFER, 0, 0, REQ_QUERY, 1023, 7, 32'hffff_ffff, 1, 40'd1},
        '{ROW_CFG, CFG_NUM_POINTS, 11'd0, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 0, 0, 32'h0, 1, 40'd1},
        '{ROW_CFG, CFG_NUM_FUNCTIONS, 11'd0, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 0, 3, 32'h5555_5555, 1, 40'd0},
        '{ROW_CFG, CFG_NUM_FUNCTIONS, 11'd1, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 1, 0, 32'h0, 1, 40'd0},
        '{ROW_CFG, CFG_NUM_POINTS, 11'd2, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 1, 0, 32'haaaa_aaaa, 0, 0},
        '{ROW_XFER, 0, 0, REQ_WRITE, 0, 0, 32'h7fff_ffff, 0, 0},
        '{ROW_CFG, CFG_NUM_FUNCTIONS, 11'd2, 0, 0, 0, 0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 0, 0, 32'h0, 0, 0},
        '{ROW_XFER, 0, 0, REQ_QUERY, 1, 0, 32'h0, 0, 0}
    };

    initial begin
        int n_cfg;
        int m_cfg;
        int items;
        logic [9:0] fn;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_cfg(rows[i].idx, rows[i].cfg_val);
            else
                send_item(rows[i].req, rows[i].fn, rows[i].pt, rows[i].val,
                          rows[i].typed, rows[i].count);
        end
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                3: n_cfg = 1024;
                7: n_cfg = 2047;
                9: n_cfg = $urandom_range(0, 1);
                default: n_cfg = $urandom_range(2, 40);
            endcase
            // full-size scans run with no points so the store needs no fill
            m_cfg = (phase == 1) ? 6 : (phase == 5) ? 7 : (phase == 6) ? 1
                    : (phase == 3 || phase == 7) ? 0 : $urandom_range(0, 7);
            write_cfg(CFG_NUM_FUNCTIONS, 11'(n_cfg));
            write_cfg(CFG_NUM_POINTS, 11'(m_cfg));
            items = (phase == 3 || phase == 7) ? 10 : 30;
            for (int k = 0; k < items; k++) begin
                if (k == items / 2) drain();
                if ($urandom_range(0, 4) == 0)
                    fn = 10'($urandom);
                else
                    fn = 10'($urandom_range(0, (n_cfg > 2 ? n_cfg : 2) + 3));
                if ($urandom_range(0, 9) < 6)
                    send_item(REQ_WRITE, fn, 3'($urandom_range(0, 7)), pick_sample(),
                              1'b0, '0);
                else
                    query_item(fn);
            end
        end
        s_tvalid = 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (1100) @(negedge aclk);
        if (fail_cnt == 0 && pending_counts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
